@@ sv/chip8_instruction_execute_macros.svh @@
// Assertion macros shared by the CHIP-8 execute block.
`ifndef CHIP8_INSTRUCTION_EXECUTE_MACROS_SVH
`define CHIP8_INSTRUCTION_EXECUTE_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define C8IE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define C8IE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/c8ie_pkg.sv @@
// Shared constants, codes and control structs of the CHIP-8 execute block.
package c8ie_pkg;

	localparam int MEM_DEPTH_DEF     = 4096;
	localparam int SCREEN_WIDTH_DEF  = 64;
	localparam int SCREEN_HEIGHT_DEF = 32;
	localparam int STACK_DEPTH_DEF   = 16;

	localparam logic [11:0] PC_RESET = 12'h200;

	// request modes
	localparam logic [2:0] MD_EXEC = 3'd0;
	localparam logic [2:0] MD_MWR  = 3'd1;
	localparam logic [2:0] MD_MRD  = 3'd2;
	localparam logic [2:0] MD_SCR  = 3'd3;
	localparam logic [2:0] MD_REG  = 3'd4;

	// result status
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_BAD   = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;
	localparam logic [1:0] ST_STACK = 2'd3;

	// follow-up work after decode
	localparam logic [3:0] C_ONE   = 4'd0;
	localparam logic [3:0] C_FLAG  = 4'd1;
	localparam logic [3:0] C_CLS   = 4'd2;
	localparam logic [3:0] C_DRAW  = 4'd3;
	localparam logic [3:0] C_BCD   = 4'd4;
	localparam logic [3:0] C_STORE = 4'd5;
	localparam logic [3:0] C_LOAD  = 4'd6;
	localparam logic [3:0] C_MRD   = 4'd7;
	localparam logic [3:0] C_SCR   = 4'd8;

	typedef struct packed {
		logic accept;
		logic rd_x;
		logic rd_y;
		logic exec;
		logic wr_res;
		logic clr;
		logic mrd;
		logic dr_mem;
		logic dr_row;
		logic dr_adv;
		logic dr_wr;
		logic dr_flag;
		logic sb_cap;
		logic bcd_wr;
		logic st_wr;
		logic ld_wr;
		logic fin_i;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic [3:0] cls;
		logic       fault;
		logic       clr_last;
		logic       dr_empty;
		logic       dr_hit;
		logic       col_last;
		logic       row_last;
		logic       bcd_last;
		logic       copy_last;
		logic       sb_last;
	} sts_t;

endpackage

@@ sv/chip8_instruction_execute.sv @@
// Top level of the CHIP-8 execute block: controller plus datapath.
// Steps: accept, read Vx and Vy, decode, then any follow-up work (Vx write-back after a flag
// ALU op, memory read, BCD digit writes, a read and a write per register in block copies,
// eight pixel reads per screen byte, a pass per sprite row for a draw, or a screen clear).
// Throughput: one request at a time; in_stall is high whenever the controller is not idle.
// Reset: a clearing pass over all SCREEN_WIDTH*SCREEN_HEIGHT (2048) pixels blanks the screen.
module chip8_instruction_execute #(
	parameter int MEM_DEPTH     = c8ie_pkg::MEM_DEPTH_DEF,
	parameter int SCREEN_WIDTH  = c8ie_pkg::SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = c8ie_pkg::SCREEN_HEIGHT_DEF,
	parameter int STACK_DEPTH   = c8ie_pkg::STACK_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  mode,
	input  logic [15:0] instruction,
	input  logic [11:0] address,
	input  logic [7:0]  write_data,
	input  logic [7:0]  random_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [11:0] program_counter,
	output logic [15:0] index_value,
	output logic [7:0]  read_data
);

	c8ie_pkg::cmd_t cmd;
	c8ie_pkg::sts_t sts;

	c8ie_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	c8ie_dp #(
		.MEM_DEPTH     (MEM_DEPTH),
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT),
		.STACK_DEPTH   (STACK_DEPTH)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.mode            (mode),
		.instruction     (instruction),
		.address         (address),
		.write_data      (write_data),
		.random_byte     (random_byte),
		.status          (status),
		.program_counter (program_counter),
		.index_value     (index_value),
		.read_data       (read_data)
	);

endmodule

@@ sv/c8ie_ctrl.sv @@
// Sequencing state machine of the CHIP-8 execute block.
`include "chip8_instruction_execute_macros.svh"

module c8ie_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	output logic           out_valid,
	input  logic           out_stall,
	input  c8ie_pkg::sts_t sts,
	output c8ie_pkg::cmd_t cmd
);

	localparam logic [4:0] S_RCLR  = 5'd0;
	localparam logic [4:0] S_IDLE  = 5'd1;
	localparam logic [4:0] S_RX    = 5'd2;
	localparam logic [4:0] S_RY    = 5'd3;
	localparam logic [4:0] S_DEC   = 5'd4;
	localparam logic [4:0] S_WRX   = 5'd5;
	localparam logic [4:0] S_CLR   = 5'd6;
	localparam logic [4:0] S_MRD   = 5'd7;
	localparam logic [4:0] S_DR_M  = 5'd8;
	localparam logic [4:0] S_DR_B  = 5'd9;
	localparam logic [4:0] S_DR_P  = 5'd10;
	localparam logic [4:0] S_DR_W  = 5'd11;
	localparam logic [4:0] S_DR_F  = 5'd12;
	localparam logic [4:0] S_BCD   = 5'd13;
	localparam logic [4:0] S_ST_RD = 5'd14;
	localparam logic [4:0] S_ST_WR = 5'd15;
	localparam logic [4:0] S_LD_RD = 5'd16;
	localparam logic [4:0] S_LD_WR = 5'd17;
	localparam logic [4:0] S_FIN   = 5'd18;
	localparam logic [4:0] S_SB_R  = 5'd19;
	localparam logic [4:0] S_SB_C  = 5'd20;
	localparam logic [4:0] S_DONE  = 5'd21;

	logic [4:0] state_q, state_nx;
	logic       out_valid_q;
	logic       dr_next_row;
	logic [4:0] dr_after;
	logic       res_held;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign res_held  = (state_q == S_DONE) && out_valid_q;

	assign dr_next_row = sts.col_last;
	always_comb begin
		if (!dr_next_row)
			dr_after = S_DR_P;
		else if (sts.row_last)
			dr_after = S_DR_F;
		else
			dr_after = S_DR_M;
	end

	always_comb begin
		cmd      = '0;
		state_nx = state_q;
		unique case (state_q)
			S_RCLR: begin
				cmd.clr = 1'b1;
				if (sts.clr_last)
					state_nx = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_nx   = S_RX;
				end
			end
			S_RX: begin
				cmd.rd_x = 1'b1;
				state_nx = S_RY;
			end
			S_RY: begin
				cmd.rd_y = 1'b1;
				state_nx = S_DEC;
			end
			S_DEC: begin
				cmd.exec = 1'b1;
				if (sts.fault)
					state_nx = S_DONE;
				else begin
					unique case (sts.cls)
						c8ie_pkg::C_FLAG:  state_nx = S_WRX;
						c8ie_pkg::C_CLS:   state_nx = S_CLR;
						c8ie_pkg::C_DRAW:  state_nx = sts.dr_empty ? S_DR_F : S_DR_M;
						c8ie_pkg::C_BCD:   state_nx = S_BCD;
						c8ie_pkg::C_STORE: state_nx = S_ST_RD;
						c8ie_pkg::C_LOAD:  state_nx = S_LD_RD;
						c8ie_pkg::C_MRD:   state_nx = S_MRD;
						c8ie_pkg::C_SCR:   state_nx = S_SB_R;
						default:           state_nx = S_DONE;
					endcase
				end
			end
			S_WRX: begin
				cmd.wr_res = 1'b1;
				state_nx   = S_DONE;
			end
			S_CLR: begin
				cmd.clr = 1'b1;
				if (sts.clr_last)
					state_nx = S_DONE;
			end
			S_MRD: begin
				cmd.mrd  = 1'b1;
				state_nx = S_DONE;
			end
			S_DR_M: begin
				cmd.dr_mem = 1'b1;
				state_nx   = S_DR_B;
			end
			S_DR_B: begin
				cmd.dr_row = 1'b1;
				state_nx   = S_DR_P;
			end
			S_DR_P: begin
				if (sts.dr_hit)
					state_nx = S_DR_W;
				else begin
					cmd.dr_adv = 1'b1;
					state_nx   = dr_after;
				end
			end
			S_DR_W: begin
				cmd.dr_wr  = 1'b1;
				cmd.dr_adv = 1'b1;
				state_nx   = dr_after;
			end
			S_DR_F: begin
				cmd.dr_flag = 1'b1;
				state_nx    = S_DONE;
			end
			S_BCD: begin
				cmd.bcd_wr = 1'b1;
				if (sts.bcd_last)
					state_nx = S_DONE;
			end
			S_ST_RD: state_nx = S_ST_WR;
			S_ST_WR: begin
				cmd.st_wr = 1'b1;
				state_nx  = sts.copy_last ? S_FIN : S_ST_RD;
			end
			S_LD_RD: state_nx = S_LD_WR;
			S_LD_WR: begin
				cmd.ld_wr = 1'b1;
				state_nx  = sts.copy_last ? S_FIN : S_LD_RD;
			end
			S_FIN: begin
				cmd.fin_i = 1'b1;
				state_nx  = S_DONE;
			end
			S_SB_R: state_nx = S_SB_C;
			S_SB_C: begin
				cmd.sb_cap = 1'b1;
				if (sts.sb_last)
					state_nx = S_DONE;
				else
					state_nx = S_SB_R;
			end
			S_DONE: begin
				if (!out_valid_q || !out_stall) begin
					cmd.load_out = 1'b1;
					state_nx     = S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_RCLR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	`C8IE_ASSERT_NEXT(a_accept_reads, in_valid && !in_stall, state_q == S_RX, "no read after accept")
	`C8IE_ASSERT_NEXT(a_fault_done, state_q == S_DEC && sts.fault, state_q == S_DONE, "fault not done")
	`C8IE_ASSERT_NEXT(a_no_overwrite, res_held && out_stall, res_held, "pending result overwritten")

endmodule

@@ sv/c8ie_dp.sv @@
// Datapath of the CHIP-8 execute block: registers, memory, screen, stack.
module c8ie_dp #(
	parameter int MEM_DEPTH     = c8ie_pkg::MEM_DEPTH_DEF,
	parameter int SCREEN_WIDTH  = c8ie_pkg::SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = c8ie_pkg::SCREEN_HEIGHT_DEF,
	parameter int STACK_DEPTH   = c8ie_pkg::STACK_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  c8ie_pkg::cmd_t cmd,
	output c8ie_pkg::sts_t sts,
	input  logic [2:0]     mode,
	input  logic [15:0]    instruction,
	input  logic [11:0]    address,
	input  logic [7:0]     write_data,
	input  logic [7:0]     random_byte,
	output logic [1:0]     status,
	output logic [11:0]    program_counter,
	output logic [15:0]    index_value,
	output logic [7:0]     read_data
);

	localparam int PIX   = SCREEN_WIDTH * SCREEN_HEIGHT;
	localparam int AW    = $clog2(MEM_DEPTH);
	localparam int PAW   = $clog2(PIX);
	localparam int POS_W = $clog2(269 * SCREEN_WIDTH + 264);
	localparam int SPW   = $clog2(STACK_DEPTH + 1);
	localparam int SIW   = $clog2(STACK_DEPTH);
	localparam logic [16:0] MEMD = 17'(MEM_DEPTH);

	// item
	logic [2:0]  mode_q;
	logic [15:0] ins_q;
	logic [11:0] addr_q;
	logic [7:0]  wdata_q, rnd_q;

	// architectural state
	logic [7:0]     rf_q [16];
	logic [15:0]    i_q;
	logic [11:0]    pc_q;
	logic [SPW-1:0] sp_q;
	logic [7:0]     dly_q;

	logic [7:0]  mem [MEM_DEPTH];
	logic        scr [PIX];
	logic [11:0] stk [STACK_DEPTH];

	logic [7:0]  rf_rd_q, mem_rd_q, vx_q, vy_q, res_q, bits_q, rd_q;
	logic        scr_rd_q, off_q;
	logic [11:0] stk_rd_q;
	logic [1:0]  st_q;
	logic [11:0] dig_q;
	logic [POS_W-1:0] rowbase_q;
	logic [3:0]  row_q;
	logic [2:0]  col_q;
	logic [PAW-1:0] cnt_q;

	logic [1:0]  status_q;
	logic [11:0] pc_out_q;
	logic [15:0] i_out_q;
	logic [7:0]  rd_out_q;

	// decode
	logic [3:0]  x, y, n;
	logic [7:0]  kk, vy;
	logic [11:0] nnn, pc_next, pc_skip, pc_nx;
	logic [1:0]  st_dec;
	logic [3:0]  cls;
	logic [7:0]  res;
	logic        flag, wr1, flagw, i_we, dly_we, push, pop;
	logic [15:0] i_nx;
	logic        exec_ok;

	// ports
	logic           rf_we;
	logic [3:0]     rf_wa, rf_ra;
	logic [7:0]     rf_wd;
	logic           mem_we;
	logic [AW-1:0]  mem_wa, mem_ra;
	logic [7:0]     mem_wd;
	logic           scr_we, scr_wd;
	logic [PAW-1:0] scr_wa, scr_ra;
	logic [16:0]    i_cnt, i_row;
	logic [POS_W-1:0] pos;

	// BCD
	logic [1:0]  hund;
	logic [6:0]  rem7;
	logic [14:0] prod;
	logic [3:0]  tens, ones;

	assign x   = ins_q[11:8];
	assign y   = ins_q[7:4];
	assign n   = ins_q[3:0];
	assign kk  = ins_q[7:0];
	assign nnn = ins_q[11:0];
	assign vy  = rf_rd_q;
	assign pc_next = pc_q + 12'd2;
	assign pc_skip = pc_q + 12'd4;

	assign i_cnt = {1'b0, i_q} + 17'(cnt_q);
	assign i_row = {1'b0, i_q} + 17'(row_q);
	assign pos   = rowbase_q + POS_W'(col_q);

	always_comb begin
		if (vx_q >= 8'd200)
			hund = 2'd2;
		else if (vx_q >= 8'd100)
			hund = 2'd1;
		else
			hund = 2'd0;
		rem7 = 7'(vx_q - 8'(hund) * 8'd100);
		prod = 15'(rem7) * 15'd205;
		tens = prod[14:11];
		ones = 4'(rem7 - 7'({tens, 3'b000}) - 7'({tens, 1'b0}));
	end

	always_comb begin
		st_dec = c8ie_pkg::ST_OK;
		cls    = c8ie_pkg::C_ONE;
		pc_nx  = pc_next;
		res    = 8'h00;
		flag   = 1'b0;
		wr1    = 1'b0;
		flagw  = 1'b0;
		i_we   = 1'b0;
		i_nx   = i_q;
		dly_we = 1'b0;
		push   = 1'b0;
		pop    = 1'b0;
		unique case (mode_q)
			c8ie_pkg::MD_EXEC: begin
				unique case (ins_q[15:12])
					4'h0: begin
						if (nnn == 12'h0E0)
							cls = c8ie_pkg::C_CLS;
						else if (nnn == 12'h0EE) begin
							if (sp_q == '0)
								st_dec = c8ie_pkg::ST_STACK;
							else begin
								pc_nx = stk_rd_q;
								pop   = 1'b1;
							end
						end else
							st_dec = c8ie_pkg::ST_BAD;
					end
					4'h1: pc_nx = nnn;
					4'h2: begin
						if (sp_q >= SPW'(STACK_DEPTH))
							st_dec = c8ie_pkg::ST_STACK;
						else begin
							pc_nx = nnn;
							push  = 1'b1;
						end
					end
					4'h3: if (vx_q == kk) pc_nx = pc_skip;
					4'h4: if (vx_q != kk) pc_nx = pc_skip;
					4'h6: begin
						wr1 = 1'b1;
						res = kk;
					end
					4'h7: begin
						wr1 = 1'b1;
						res = vx_q + kk;
					end
					4'h8: begin
						unique case (n)
							4'h0: begin wr1 = 1'b1; res = vy; end
							4'h2: begin wr1 = 1'b1; res = vx_q & vy; end
							4'h3: begin wr1 = 1'b1; res = vx_q ^ vy; end
							4'h4: begin
								flagw       = 1'b1;
								{flag, res} = {1'b0, vx_q} + {1'b0, vy};
							end
							4'h5: begin
								flagw = 1'b1;
								flag  = (vx_q >= vy);
								res   = vx_q - vy;
							end
							4'h6: begin
								flagw = 1'b1;
								flag  = vy[0];
								res   = {1'b0, vy[7:1]};
							end
							4'hE: begin
								flagw = 1'b1;
								flag  = vy[7];
								res   = {vy[6:0], 1'b0};
							end
							default: st_dec = c8ie_pkg::ST_BAD;
						endcase
						if (flagw)
							cls = c8ie_pkg::C_FLAG;
					end
					4'hA: begin
						i_we = 1'b1;
						i_nx = {4'h0, nnn};
					end
					4'hC: begin
						wr1 = 1'b1;
						res = rnd_q & kk;
					end
					4'hD: begin
						cls = c8ie_pkg::C_DRAW;
						if ({1'b0, i_q} + 17'(n) > MEMD)
							st_dec = c8ie_pkg::ST_RANGE;
					end
					4'hE: begin
						if (kk == 8'hA1)
							pc_nx = pc_skip;
						else
							st_dec = c8ie_pkg::ST_BAD;
					end
					4'hF: begin
						unique case (kk)
							8'h07: begin wr1 = 1'b1; res = dly_q; end
							8'h15: dly_we = 1'b1;
							8'h18: ;
							8'h1E: begin i_we = 1'b1; i_nx = i_q + {8'h00, vx_q}; end
							8'h29: begin
								i_we = 1'b1;
								i_nx = {6'd0, vx_q, 2'b00} + {8'h00, vx_q};
							end
							8'h33: begin
								cls = c8ie_pkg::C_BCD;
								if ({1'b0, i_q} + 17'd2 >= MEMD)
									st_dec = c8ie_pkg::ST_RANGE;
							end
							8'h55, 8'h65: begin
								cls = (kk == 8'h55) ? c8ie_pkg::C_STORE : c8ie_pkg::C_LOAD;
								if ({1'b0, i_q} + 17'(x) + 17'd1 > MEMD)
									st_dec = c8ie_pkg::ST_RANGE;
							end
							default: st_dec = c8ie_pkg::ST_BAD;
						endcase
					end
					default: st_dec = c8ie_pkg::ST_BAD;
				endcase
			end
			c8ie_pkg::MD_MWR: begin
				if (17'(addr_q) >= MEMD)
					st_dec = c8ie_pkg::ST_RANGE;
			end
			c8ie_pkg::MD_MRD: begin
				cls = c8ie_pkg::C_MRD;
				if (17'(addr_q) >= MEMD)
					st_dec = c8ie_pkg::ST_RANGE;
			end
			c8ie_pkg::MD_SCR: begin
				cls = c8ie_pkg::C_SCR;
				if (32'(addr_q) >= 32'(PIX / 8))
					st_dec = c8ie_pkg::ST_RANGE;
			end
			c8ie_pkg::MD_REG: begin
				if (addr_q > 12'd15)
					st_dec = c8ie_pkg::ST_RANGE;
			end
			default: st_dec = c8ie_pkg::ST_BAD;
		endcase
	end

	assign exec_ok = cmd.exec && (st_dec == c8ie_pkg::ST_OK);

	assign sts.cls       = cls;
	assign sts.fault     = (st_dec != c8ie_pkg::ST_OK);
	assign sts.clr_last  = (cnt_q == PAW'(PIX - 1));
	assign sts.dr_empty  = (n == 4'd0);
	assign sts.dr_hit    = bits_q[3'd7 - col_q] && (pos < POS_W'(PIX));
	assign sts.col_last  = (col_q == 3'd7);
	assign sts.row_last  = ((row_q + 4'd1) == n);
	assign sts.bcd_last  = (cnt_q[3:0] == 4'd2);
	assign sts.copy_last = (cnt_q[3:0] == x);
	assign sts.sb_last   = (cnt_q[3:0] == 4'd7);

	// register file ports
	always_comb begin
		if (cmd.rd_x)
			rf_ra = (mode_q == c8ie_pkg::MD_REG) ? addr_q[3:0] : x;
		else if (cmd.rd_y)
			rf_ra = y;
		else
			rf_ra = cnt_q[3:0];
		rf_we = 1'b0;
		rf_wa = x;
		rf_wd = res;
		priority if (exec_ok && wr1) begin
			rf_we = 1'b1;
		end else if (exec_ok && flagw) begin
			rf_we = 1'b1;
			rf_wa = 4'hF;
			rf_wd = {7'd0, flag};
		end else if (cmd.wr_res) begin
			rf_we = 1'b1;
			rf_wd = res_q;
		end else if (cmd.dr_flag) begin
			rf_we = 1'b1;
			rf_wa = 4'hF;
			rf_wd = {7'd0, off_q};
		end else if (cmd.ld_wr) begin
			rf_we = 1'b1;
			rf_wa = cnt_q[3:0];
			rf_wd = mem_rd_q;
		end
	end

	// main memory ports
	always_comb begin
		if (cmd.exec)
			mem_ra = AW'(addr_q);
		else if (cmd.dr_mem)
			mem_ra = AW'(i_row);
		else
			mem_ra = AW'(i_cnt);
		mem_we = 1'b0;
		mem_wa = AW'(i_cnt);
		mem_wd = rf_rd_q;
		priority if (exec_ok && mode_q == c8ie_pkg::MD_MWR) begin
			mem_we = 1'b1;
			mem_wa = AW'(addr_q);
			mem_wd = wdata_q;
		end else if (cmd.bcd_wr) begin
			mem_we = 1'b1;
			mem_wd = {4'h0, dig_q[11:8]};
		end else if (cmd.st_wr) begin
			mem_we = 1'b1;
		end
	end

	// screen ports
	always_comb begin
		scr_ra = (mode_q == c8ie_pkg::MD_SCR) ? PAW'({addr_q, cnt_q[2:0]}) : pos[PAW-1:0];
		scr_we = cmd.clr || cmd.dr_wr;
		scr_wa = cmd.clr ? cnt_q : pos[PAW-1:0];
		scr_wd = cmd.clr ? 1'b0 : !scr_rd_q;
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= mem_wd;
		mem_rd_q <= mem[mem_ra];
	end

	always_ff @(posedge clk) begin
		if (scr_we)
			scr[scr_wa] <= scr_wd;
		scr_rd_q <= scr[scr_ra];
	end

	always_ff @(posedge clk) begin
		if (exec_ok && push)
			stk[SIW'(sp_q)] <= pc_next;
		stk_rd_q <= stk[SIW'(sp_q - 1'b1)];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 16; k++)
				rf_q[k] <= 8'h00;
			i_q   <= 16'h0000;
			pc_q  <= c8ie_pkg::PC_RESET;
			sp_q  <= '0;
			dly_q <= 8'h00;
			cnt_q <= '0;
		end else begin
			if (rf_we)
				rf_q[rf_wa] <= rf_wd;
			if (exec_ok && mode_q == c8ie_pkg::MD_EXEC) begin
				pc_q <= pc_nx;
				if (i_we)
					i_q <= i_nx;
				if (dly_we)
					dly_q <= vx_q;
				if (push)
					sp_q <= sp_q + 1'b1;
				else if (pop)
					sp_q <= sp_q - 1'b1;
			end
			if (cmd.fin_i)
				i_q <= i_q + 16'(x) + 16'd1;
			if (cmd.accept)
				cnt_q <= '0;
			else if (cmd.clr || cmd.bcd_wr || cmd.st_wr || cmd.ld_wr || cmd.sb_cap)
				cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		rf_rd_q <= rf_q[rf_ra];
		if (cmd.accept) begin
			mode_q  <= mode;
			ins_q   <= instruction;
			addr_q  <= address;
			wdata_q <= write_data;
			rnd_q   <= random_byte;
			rd_q    <= 8'h00;
		end
		if (cmd.rd_y)
			vx_q <= rf_rd_q;
		if (cmd.exec) begin
			vy_q   <= rf_rd_q;
			res_q  <= res;
			st_q   <= st_dec;
			dig_q  <= {2'b00, hund, tens, ones};
			row_q  <= 4'd0;
			col_q  <= 3'd0;
			off_q  <= 1'b0;
			if (exec_ok && mode_q == c8ie_pkg::MD_REG)
				rd_q <= vx_q;
		end
		if (cmd.mrd)
			rd_q <= mem_rd_q;
		if (cmd.sb_cap)
			rd_q <= {rd_q[6:0], scr_rd_q};
		if (cmd.bcd_wr)
			dig_q <= {dig_q[7:0], 4'h0};
		if (cmd.dr_row) begin
			bits_q    <= mem_rd_q;
			rowbase_q <= POS_W'(vx_q) + POS_W'(({1'b0, vy_q} + 9'(row_q)) * SCREEN_WIDTH);
		end
		if (cmd.dr_wr && scr_rd_q)
			off_q <= 1'b1;
		if (cmd.dr_adv) begin
			col_q <= col_q + 3'd1;
			if (col_q == 3'd7)
				row_q <= row_q + 4'd1;
		end
		if (cmd.load_out) begin
			status_q <= st_q;
			pc_out_q <= pc_q;
			i_out_q  <= i_q;
			rd_out_q <= rd_q;
		end
	end

	assign status          = status_q;
	assign program_counter = pc_out_q;
	assign index_value     = i_out_q;
	assign read_data       = rd_out_q;

endmodule
